// ----- hw/rtl/wglr_pkg.sv -----
// Shared constants for the windowed GLR Poisson detector.
`default_nettype none
package wglr_pkg;
  localparam int SX_W = 22;  // sum of up to 64 counts
  localparam int SM_W = 30;  // sum of up to 64 Q8.16 means
  localparam int A_W  = 38;  // sx scaled to Q16
  localparam int LG_W = 22;  // log2 result, Q16
  localparam int SC_W = 48;  // signed score, Q16
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  localparam logic [1:0] CFG_WINDOW_MAX = 2'd0;
  localparam logic [1:0] CFG_MIN_LEN    = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD  = 2'd2;
endpackage
`default_nettype wire

// ----- hw/rtl/wglr_log2.sv -----
// Iterative log2 unit, Q16 result, one squaring per cycle.
`default_nettype none
module wglr_log2 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [wglr_pkg::A_W-1:0]  v_i,
  output logic                      done_o,
  output logic [wglr_pkg::LG_W-1:0] res_o
);
  import wglr_pkg::*;

  logic [5:0]       e;
  logic [A_W-1:0]   shl, shr;
  logic [30:0]      norm;
  logic [30:0]      m_q;
  logic [LG_W-1:0]  r_q;
  logic [3:0]       it_q;
  logic             busy_q, done_q;
  logic [61:0]      sq;
  logic [31:0]      sq_s;

  always_comb begin
    e = '0;
    for (int i = 0; i < A_W; i++) begin
      if (v_i[i]) e = 6'(i);
    end
    shr  = v_i >> (e - 6'd30);
    shl  = v_i << (6'd30 - e);
    norm = (e >= 6'd30) ? shr[30:0] : shl[30:0];
  end

  assign sq   = {31'b0, m_q} * {31'b0, m_q};
  assign sq_s = sq[61:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        it_q   <= 4'd15;
      end else if (busy_q) begin
        it_q <= it_q - 4'd1;
        if (it_q == 4'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q <= norm;
      r_q <= {e, 16'b0};
    end else if (busy_q) begin
      if (sq_s[31]) begin
        r_q[it_q] <= 1'b1;
        m_q       <= sq_s[31:1];
      end else begin
        m_q <= sq_s[30:0];
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = r_q;
endmodule
`default_nettype wire

// ----- hw/rtl/wglr_seg_score.sv -----
// Segment score sequencer: log ratio, kappa and score for one start.
`default_nettype none
module wglr_seg_score (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [wglr_pkg::SX_W-1:0]        sx_i,
  input  logic [wglr_pkg::SM_W-1:0]        sm_i,
  output logic                             done_o,
  output logic signed [wglr_pkg::SC_W-1:0] score_o
);
  import wglr_pkg::*;

  typedef enum logic [2:0] {SS_IDLE, SS_CMP, SS_LOGA, SS_LOGB, SS_KAP, SS_SUM} ss_e;

  ss_e                    state_q;
  logic [A_W-1:0]         a_q;
  logic [SM_W-1:0]        b_q;
  logic [SX_W-1:0]        sx_q;
  logic [LG_W-1:0]        la_q, kap_q;
  logic [43:0]            prod_q;
  logic signed [SC_W-1:0] score_q;
  logic                   done_q;
  logic                   lg_start, lg_done;
  logic [A_W-1:0]         lg_v;
  logic [LG_W-1:0]        lg_res;
  logic [51:0]            kprod;

  assign lg_start = (state_q == SS_CMP && a_q > {8'b0, b_q}) ||
                    (state_q == SS_LOGA && lg_done);
  assign lg_v     = (state_q == SS_CMP) ? a_q : {8'b0, b_q};
  assign kprod    = {8'b0, la_q - lg_res} * {22'b0, LN2_Q30};

  wglr_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lg_start),
    .v_i     (lg_v),
    .done_o  (lg_done),
    .res_o   (lg_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SS_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        SS_IDLE: begin
          if (start_i) begin
            a_q     <= {sx_i, 16'b0};
            b_q     <= (sm_i == '0) ? SM_W'(1) : sm_i;
            sx_q    <= sx_i;
            state_q <= SS_CMP;
          end
        end
        SS_CMP: begin
          if (a_q <= {8'b0, b_q}) begin
            score_q <= '0;
            done_q  <= 1'b1;
            state_q <= SS_IDLE;
          end else begin
            state_q <= SS_LOGA;
          end
        end
        SS_LOGA: begin
          if (lg_done) begin
            la_q    <= lg_res;
            state_q <= SS_LOGB;
          end
        end
        SS_LOGB: begin
          if (lg_done) begin
            if (lg_res >= la_q) begin
              score_q <= '0;
              done_q  <= 1'b1;
              state_q <= SS_IDLE;
            end else begin
              kap_q   <= kprod[51:30];
              state_q <= SS_KAP;
            end
          end
        end
        SS_KAP: begin
          if (kap_q == '0) begin
            score_q <= '0;
            done_q  <= 1'b1;
            state_q <= SS_IDLE;
          end else begin
            prod_q  <= kap_q * sx_q;
            state_q <= SS_SUM;
          end
        end
        SS_SUM: begin
          score_q <= $signed({4'b0, prod_q}) + $signed({18'b0, b_q})
                     - $signed({10'b0, sx_q, 16'b0});
          done_q  <= 1'b1;
          state_q <= SS_IDLE;
        end
        default: state_q <= SS_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign score_o = score_q;
endmodule
`default_nettype wire

// ----- hw/rtl/windowed_glr_poisson_detector.sv -----
// Top level: history memories, look-back walk and alarm logic.
// When no start is scored a transaction goes from idle straight to done; otherwise each
// visited entry adds a read and an accumulate step, and each scored start up to two log2
// runs in the shared unit, with at most 64 visited entries per transaction.
// One transaction at a time; the result register frees input while a result waits.
// Reset clears control state and registers to defaults; history memories are not cleared.
`default_nettype none
module windowed_glr_poisson_detector #(
  parameter int WINDOW = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] count_i,
  input  logic [23:0] mean_i,
  input  logic        new_series_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] statistic_o,
  output logic        ready_res_o,
  output logic        alarm_o,
  output logic        stopped_o,
  output logic [15:0] alarm_time_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i
);
  import wglr_pkg::*;

  localparam int AW      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int XW      = ((AW > 6) ? AW : 6) + 1;
  localparam int LIM_CAP = (WINDOW - 1 > 63) ? 63 : WINDOW - 1;

  typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_ACC, ST_SCORE, ST_DONE} st_e;

  st_e                    state_q;
  logic [5:0]             wmax_q, minl_q;
  logic [30:0]            thr_q;
  logic [AW-1:0]          slot_q, cur_q;
  logic [15:0]            series_q, n_q;
  logic                   stopped_q, ws_q, rdy_q, have_q;
  logic [5:0]             dmax_q, d_q;
  logic [SX_W-1:0]        sx_q;
  logic [SM_W-1:0]        sm_q;
  logic signed [SC_W-1:0] best_q;

  logic [15:0]     count_mem [WINDOW];
  logic [23:0]     mean_mem  [WINDOW];
  logic [15:0]     rcnt_q;
  logic [23:0]     rmean_q;

  logic            in_acc, out_free;
  logic [15:0]     n_acc;
  logic [AW-1:0]   slot_acc, slot_nxt, raddr;
  logic [5:0]      lim, dmax;
  logic            rdy_acc;
  logic [XW-1:0]   cur_x, d_x, addr_x;
  logic [SX_W-1:0] sx_new;
  logic [SM_W-1:0] sm_new;
  logic            sc_start, sc_done;
  logic signed [SC_W-1:0] sc_score;
  logic            alarm;
  logic [16:0]     n_inc;
  logic signed [31:0] stat;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_o || out_ready_i;

  assign n_acc    = new_series_i ? 16'd0 : series_q;
  assign slot_acc = new_series_i ? '0 : slot_q;
  assign slot_nxt = ({{(XW-AW){1'b0}}, slot_acc} == XW'(WINDOW - 1)) ? '0 : slot_acc + 1'b1;
  assign lim      = (wmax_q < 6'(LIM_CAP)) ? wmax_q : 6'(LIM_CAP);
  assign dmax     = (n_acc < {10'b0, lim}) ? n_acc[5:0] : lim;
  assign rdy_acc  = n_acc >= {10'b0, minl_q};

  assign cur_x  = {{(XW-AW){1'b0}}, cur_q};
  assign d_x    = {{(XW-6){1'b0}}, d_q};
  assign addr_x = (cur_x >= d_x) ? cur_x - d_x : cur_x + XW'(WINDOW) - d_x;
  assign raddr  = addr_x[AW-1:0];

  assign sx_new   = sx_q + {6'b0, rcnt_q};
  assign sm_new   = sm_q + {6'b0, rmean_q};
  assign sc_start = (state_q == ST_ACC) && (d_q >= minl_q);

  wglr_seg_score u_score (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sc_start),
    .sx_i    (sx_new),
    .sm_i    (sm_new),
    .done_o  (sc_done),
    .score_o (sc_score)
  );

  assign alarm = rdy_q && have_q && !ws_q && (best_q > $signed({17'b0, thr_q}));
  assign n_inc = {1'b0, n_q} + 17'd1;
  always_comb begin
    if (!rdy_q)                                   stat = '0;
    else if (!have_q)                             stat = 32'sh8000_0000;
    else if (best_q > SC_W'(32'sh7FFF_FFFF))      stat = 32'sh7FFF_FFFF;
    else if (best_q < -SC_W'(33'sh0_8000_0000))   stat = 32'sh8000_0000;
    else                                          stat = best_q[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      count_mem[slot_acc] <= count_i;
      mean_mem[slot_acc]  <= mean_i;
    end
    rcnt_q  <= count_mem[raddr];
    rmean_q <= mean_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wmax_q       <= 6'd50;
      minl_q       <= 6'd5;
      thr_q        <= 31'd327680;
      slot_q       <= '0;
      series_q     <= '0;
      stopped_q    <= 1'b0;
      out_valid_o  <= 1'b0;
      cur_q        <= '0;
      n_q          <= '0;
      ws_q         <= 1'b0;
      rdy_q        <= 1'b0;
      have_q       <= 1'b0;
      dmax_q       <= '0;
      d_q          <= '0;
      sx_q         <= '0;
      sm_q         <= '0;
      best_q       <= '0;
      statistic_o  <= '0;
      ready_res_o  <= 1'b0;
      alarm_o      <= 1'b0;
      stopped_o    <= 1'b0;
      alarm_time_o <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_WINDOW_MAX: wmax_q <= cfg_data_i[5:0];
          CFG_MIN_LEN:    minl_q <= cfg_data_i[5:0];
          CFG_THRESHOLD:  thr_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            cur_q     <= slot_acc;
            slot_q    <= slot_nxt;
            n_q       <= n_acc;
            series_q  <= (n_acc == 16'hFFFF) ? n_acc : n_acc + 16'd1;
            ws_q      <= new_series_i ? 1'b0 : stopped_q;
            stopped_q <= new_series_i ? 1'b0 : stopped_q;
            rdy_q     <= rdy_acc;
            dmax_q    <= dmax;
            d_q       <= '0;
            sx_q      <= '0;
            sm_q      <= '0;
            have_q    <= 1'b0;
            best_q    <= '0;
            state_q   <= (rdy_acc && minl_q <= dmax) ? ST_RD : ST_DONE;
          end
        end
        ST_RD: state_q <= ST_ACC;
        ST_ACC: begin
          sx_q <= sx_new;
          sm_q <= sm_new;
          if (sc_start) begin
            state_q <= ST_SCORE;
          end else if (d_q == dmax_q) begin
            state_q <= ST_DONE;
          end else begin
            d_q     <= d_q + 6'd1;
            state_q <= ST_RD;
          end
        end
        ST_SCORE: begin
          if (sc_done) begin
            if (!have_q || sc_score > best_q) best_q <= sc_score;
            have_q <= 1'b1;
            if (d_q == dmax_q) begin
              state_q <= ST_DONE;
            end else begin
              d_q     <= d_q + 6'd1;
              state_q <= ST_RD;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_o  <= 1'b1;
            statistic_o  <= stat;
            ready_res_o  <= rdy_q;
            alarm_o      <= alarm;
            stopped_o    <= ws_q;
            alarm_time_o <= alarm ? (n_inc[16] ? 16'hFFFF : n_inc[15:0]) : 16'd0;
            if (alarm) stopped_q <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/wglr_checker.sv -----
// Port-level checker for the detector, bound to the top level.
`default_nettype none
module wglr_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [31:0] statistic_o,
  input wire        ready_res_o,
  input wire        alarm_o,
  input wire        stopped_o,
  input wire [15:0] alarm_time_o
);
  a_alarm_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alarm_o |-> ready_res_o && !stopped_o) else $error("alarm without ready");
  a_alarm_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !alarm_o |-> alarm_time_o == 16'd0) else $error("stray alarm time");
  a_alarm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alarm_o |-> alarm_time_o != 16'd0) else $error("zero alarm time");
  a_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ready_res_o |-> statistic_o == 32'd0) else $error("stat when not ready");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(statistic_o) &&
    $stable(alarm_o) && $stable(alarm_time_o)) else $error("result dropped while stalled");
endmodule

bind windowed_glr_poisson_detector wglr_checker u_wglr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .statistic_o  (statistic_o),
  .ready_res_o  (ready_res_o),
  .alarm_o      (alarm_o),
  .stopped_o    (stopped_o),
  .alarm_time_o (alarm_time_o)
);
`default_nettype wire

// ----- bench/tb_windowed_glr_poisson_detector.sv -----
// Testbench for the windowed GLR Poisson detector: directed, random and backpressure checks.
`default_nettype none
module tb_windowed_glr_poisson_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import wglr_pkg::*;

  localparam int DEPTH = 64;
  localparam longint unsigned LN2_FIX = 64'd744261118;

  typedef struct packed {
    logic signed [31:0] statistic;
    logic               ready_res;
    logic               alarm;
    logic               stopped;
    logic [15:0]        alarm_time;
  } glr_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] count_i = '0;
  logic [23:0] mean_i = 24'd1;
  logic        new_series_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [31:0] statistic_o;
  logic        ready_res_o;
  logic        alarm_o;
  logic        stopped_o;
  logic [15:0] alarm_time_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [30:0] cfg_data_i = '0;

  windowed_glr_poisson_detector #(.WINDOW(DEPTH)) dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("tb_windowed_glr_poisson_detector: errors");
    $finish;
  end

  // predictor state
  logic [15:0] hist_count [DEPTH];
  logic [23:0] hist_mean [DEPTH];
  int unsigned slot_ptr, series_pos;
  bit          latched_stop;
  int unsigned lookback_max, min_span;
  longint      alarm_level;

  glr_result_t pending_results[$];
  int          mismatches = 0;
  int          hold_off = 0;

  function automatic longint log2_fix(longint unsigned v);
    int unsigned e;
    longint unsigned m;
    longint r;
    e = 0;
    while (e < 63 && (v >> (e + 1)) != 0) e++;
    m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
    r = longint'(e) * 65536;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        r += longint'(1) << i;
        m >>= 1;
      end
    end
    return r;
  endfunction

  function automatic longint segment_glr(longint unsigned sx, longint unsigned sm);
    longint unsigned a, b;
    longint l, kappa;
    a = sx << 16;
    b = (sm == 0) ? 1 : sm;
    if (a <= b) return 0;
    l = log2_fix(a) - log2_fix(b);
    if (l <= 0) return 0;
    kappa = longint'((unsigned'(l) * LN2_FIX) >> 30);
    if (kappa == 0) return 0;
    return kappa * longint'(sx) + longint'(b) - longint'(sx << 16);
  endfunction

  function automatic glr_result_t predict_glr(logic [15:0] cnt, logic [23:0] mu, logic fresh);
    glr_result_t r;
    int unsigned cur, n, lim, dmax, slot;
    longint unsigned sx, sm;
    longint best, s;
    bit have, ready;
    r = '0;
    sx = 0;
    sm = 0;
    best = 0;
    have = 0;
    if (fresh) begin
      series_pos = 0;
      latched_stop = 0;
      slot_ptr = 0;
    end
    cur = slot_ptr;
    hist_count[cur] = cnt;
    hist_mean[cur] = mu;
    slot_ptr = (cur + 1) % DEPTH;
    n = series_pos;
    if (series_pos < 65535) series_pos++;
    r.stopped = latched_stop;
    ready = n >= min_span;
    r.ready_res = ready;
    if (ready) begin
      lim = (lookback_max < DEPTH - 1) ? lookback_max : DEPTH - 1;
      dmax = (lim < n) ? lim : n;
      if (min_span <= dmax) begin
        for (int unsigned d = 0; d <= dmax; d++) begin
          slot = (cur + DEPTH - d) % DEPTH;
          sx += hist_count[slot];
          sm += hist_mean[slot];
          if (d >= min_span) begin
            s = segment_glr(sx, sm);
            if (!have || s > best) begin
              best = s;
              have = 1;
            end
          end
        end
      end
      if (have && !latched_stop && best > alarm_level) begin
        r.alarm = 1'b1;
        latched_stop = 1;
        r.alarm_time = (n + 1 > 65535) ? 16'hFFFF : 16'(n + 1);
      end
    end
    if (!ready) r.statistic = 0;
    else if (!have) r.statistic = 32'sh8000_0000;
    else if (best > 64'sd2147483647) r.statistic = 32'sh7FFF_FFFF;
    else if (best < -64'sd2147483648) r.statistic = 32'sh8000_0000;
    else r.statistic = 32'(best);
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    glr_result_t got, want;
    if (out_valid_o && out_ready_i) begin
      got = '{statistic_o, ready_res_o, alarm_o, stopped_o, alarm_time_o};
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("unexpected transaction: %p", got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatches < 10) $display("mismatch: expected %p actual %p", want, got);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stall pattern plus optional long hold-off
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        out_ready_i <= 1'b0;
        hold_off--;
      end else begin
        if ($urandom_range(0, 31) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_item(logic [15:0] cnt, logic [23:0] mu, logic fresh);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    count_i <= cnt;
    mean_i <= mu;
    new_series_i <= fresh;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_glr(cnt, mu, fresh));
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    pause_sender(0);
    while (pending_results.size() != 0 && guard < 400_000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_results.size() != 0) mismatches++;
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_WINDOW_MAX: lookback_max = data[5:0];
      CFG_MIN_LEN:    min_span = data[5:0];
      default:        alarm_level = data;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(int wmax, int mlen, longint thr);
    write_reg(CFG_WINDOW_MAX, 31'(wmax));
    write_reg(CFG_MIN_LEN, 31'(mlen));
    write_reg(CFG_THRESHOLD, 31'(thr));
  endtask

  // random count around the mean, with an optional upward shift
  task automatic send_random(int shift, logic fresh);
    logic [23:0] mu;
    int lam;
    mu = 24'($urandom_range(32768, 262144));
    lam = (mu >> 16) + shift;
    send_item(16'($urandom_range(0, 2 * lam + 1)), mu, fresh);
    if ($urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 12));
  endtask

  task automatic test_defaults();
    send_item(16'd0, 24'd1, 1'b1);
    for (int i = 0; i < 7; i++) send_item(16'd3, 24'd65536, 1'b0);
    send_item(16'd65535, 24'd1, 1'b0);
    send_item(16'd0, 24'hFFFFFF, 1'b0);
    send_item(16'd65535, 24'hFFFFFF, 1'b0);
    send_item(16'd40, 24'd65536, 1'b0);
    drain();
  endtask

  task automatic test_extremes();
    set_config(63, 1, 0);
    send_item(16'd0, 24'd65536, 1'b1);
    for (int i = 0; i < 5; i++) send_item(16'(i * 9), 24'(65536 * (i + 1)), 1'b0);
    drain();
    set_config(1, 1, 31'h7FFF_FFFF);
    send_item(16'd65535, 24'd1, 1'b1);
    send_item(16'd65535, 24'd1, 1'b0);
    send_item(16'hAAAA, 24'h555555, 1'b0);
    drain();
    set_config(3, 10, 100);
    for (int i = 0; i < 4; i++) send_item(16'd50, 24'd65536, i == 0);
    for (int i = 0; i < 8; i++) send_item(16'd50, 24'd65536, 1'b0);
    drain();
  endtask

  task automatic test_random();
    int shift;
    set_config(12, 3, 5 * 65536);
    for (int i = 0; i < 33; i++) begin
      shift = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 8) : 0;
      send_random(shift, $urandom_range(0, 19) == 0);
    end
    drain();
    set_config(63, 20, 30 * 65536);
    send_item(16'd1, 24'd65536, 1'b1);
    for (int i = 0; i < 35; i++) send_random(i > 20 ? 5 : 0, 1'b0);
    drain();
    set_config($urandom_range(1, 10), $urandom_range(1, 6), $urandom_range(0, 20 * 65536));
    for (int i = 0; i < 30; i++) send_random($urandom_range(0, 4), $urandom_range(0, 9) == 0);
    drain();
  endtask

  task automatic test_backpressure();
    set_config(4, 2, 2 * 65536);
    hold_off = 400;
    for (int i = 0; i < 8; i++) send_item(16'($urandom), 24'($urandom_range(1, 24'hFFFFFF)), i == 0);
    drain();
  endtask

  initial begin
    lookback_max = 50;
    min_span = 5;
    alarm_level = 327680;
    slot_ptr = 0;
    series_pos = 0;
    latched_stop = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    test_defaults();
    test_extremes();
    test_backpressure();
    test_random();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_windowed_glr_poisson_detector: clean");
    end else begin
      $display("tb_windowed_glr_poisson_detector: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
